// File: sv/vem_pkg.sv
// ----------------------------------------------------------------------------
// vem_pkg: shared constants and types for vector error metrics
// Sequencer step codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vem_pkg;

	localparam int MAX_LEN = 65536;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int ACC_W   = 48;
	localparam int ROOT_W  = ACC_W / 2;
	localparam int DIV_W   = 64;

	// finishing sequence, run in this order
	localparam logic [3:0] STEP_DIV_MSE = 4'd0;
	localparam logic [3:0] STEP_SQ_MSE  = 4'd1;
	localparam logic [3:0] STEP_SQ_REF  = 4'd2;
	localparam logic [3:0] STEP_SQ_TEST = 4'd3;
	localparam logic [3:0] STEP_SQ_DIFF = 4'd4;
	localparam logic [3:0] STEP_MUL_DEN = 4'd5;
	localparam logic [3:0] STEP_DIV_COS = 4'd6;
	localparam logic [3:0] STEP_DIV_REL = 4'd7;

	typedef struct packed {
		logic       in_en;    // items may be taken
		logic       start;    // launch step
		logic [3:0] step;
		logic       publish;  // load result, clear accumulators
	} vem_cmd_t;

	typedef struct packed {
		logic unit_done;
		logic out_busy;
	} vem_status_t;

endpackage

// File: sv/vem_ctrl.sv
// ----------------------------------------------------------------------------
// vem_ctrl: sequencer for vector error metrics
// Accepts pairs, then walks the divide/root/multiply steps after the last one.
// ----------------------------------------------------------------------------
module vem_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	input  vem_pkg::vem_status_t status,
	output vem_pkg::vem_cmd_t    cmd
);

	localparam logic [2:0] ST_ACC   = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_GO    = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_PUB   = 3'd4;

	logic [2:0] state_q;
	logic [3:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= vem_pkg::STEP_DIV_MSE;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (in_valid && in_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					step_q  <= vem_pkg::STEP_DIV_MSE;
					state_q <= ST_GO;
				end
				ST_GO: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (status.unit_done) begin
						if (step_q == vem_pkg::STEP_DIV_REL) begin
							state_q <= ST_PUB;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= ST_GO;
						end
					end
				end
				ST_PUB: begin
					if (!status.out_busy) state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	always_comb begin
		cmd.in_en   = (state_q == ST_ACC);
		cmd.start   = (state_q == ST_GO);
		cmd.step    = step_q;
		cmd.publish = (state_q == ST_PUB) && !status.out_busy;
	end

endmodule

// File: sv/vem_dp.sv
// ----------------------------------------------------------------------------
// vem_dp: datapath for vector error metrics
// Product stage, saturating accumulators, shared radix-2 divider and
// shared digit-by-digit square root, result register.
// ----------------------------------------------------------------------------
module vem_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vem_pkg::vem_cmd_t    cmd,
	output vem_pkg::vem_status_t status,
	input  logic                 in_accept,
	input  logic signed [15:0]   sample_ref,
	input  logic signed [15:0]   sample_test,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [31:0]          mean_sq_err,
	output logic [15:0]          root_mean_sq_err,
	output logic [15:0]          peak_abs_err,
	output logic signed [15:0]   cosine_sim,
	output logic [15:0]          relative_l2,
	output logic                 length_overflow
);

	localparam int AW = vem_pkg::ACC_W;
	localparam int RW = vem_pkg::ROOT_W;
	localparam int DW = vem_pkg::DIV_W;
	localparam int CW = vem_pkg::CNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(vem_pkg::MAX_LEN);

	// ---------------- count and product stage
	logic [CW-1:0]      cnt_q;
	logic               ovf_q;
	logic               vld_s1;
	logic [16:0]        ad_s1;
	logic [33:0]        psq_s1;
	logic signed [31:0] px_s1;
	logic [31:0]        pr_s1, pt_s1;

	logic signed [16:0] diff;
	logic [16:0]        adiff;
	logic               keep;

	assign diff  = 17'(sample_ref) - 17'(sample_test);
	assign adiff = diff[16] ? 17'(-diff) : diff;
	assign keep  = in_accept && (cnt_q < MAX_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= keep;
			if (cmd.publish) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (keep) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (in_accept) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ad_s1  <= adiff;
		psq_s1 <= adiff * adiff;
		px_s1  <= sample_ref * sample_test;
		pr_s1  <= 32'(sample_ref) * 32'(sample_ref);
		pt_s1  <= 32'(sample_test) * 32'(sample_test);
	end

	// ---------------- accumulators
	logic [AW-1:0]        sq_q, rs_q, ts_q;
	logic signed [AW-1:0] x_q;
	logic [16:0]          peak_q;
	logic [AW:0]          sq_sum, rs_sum, ts_sum;
	logic signed [AW:0]   x_sum;

	assign sq_sum = {1'b0, sq_q} + (AW+1)'(psq_s1);
	assign rs_sum = {1'b0, rs_q} + (AW+1)'(pr_s1);
	assign ts_sum = {1'b0, ts_q} + (AW+1)'(pt_s1);
	assign x_sum  = (AW+1)'(x_q) + (AW+1)'(px_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q   <= '0;
			rs_q   <= '0;
			ts_q   <= '0;
			x_q    <= '0;
			peak_q <= '0;
		end else if (cmd.publish) begin
			sq_q   <= '0;
			rs_q   <= '0;
			ts_q   <= '0;
			x_q    <= '0;
			peak_q <= '0;
		end else if (vld_s1) begin
			sq_q <= sq_sum[AW] ? '1 : sq_sum[AW-1:0];
			rs_q <= rs_sum[AW] ? '1 : rs_sum[AW-1:0];
			ts_q <= ts_sum[AW] ? '1 : ts_sum[AW-1:0];
			if (x_sum[AW] != x_sum[AW-1])
				x_q <= x_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
			else
				x_q <= x_sum[AW-1:0];
			if (ad_s1 > peak_q) peak_q <= ad_s1;
		end
	end

	// ---------------- shared divider, one quotient bit per cycle
	logic [DW-1:0] dv_num_q, dv_quo_q;
	logic [AW-1:0] dv_den_q;
	logic [AW-1:0] dv_rem_q;
	logic [6:0]    dv_cnt_q;
	logic          dv_busy_q, dv_done_q;
	logic [AW:0]   dv_shift;
	logic          dv_ge;

	// ---------------- shared square root, one root bit per cycle
	logic [AW-1:0] sr_val_q;
	logic [RW+1:0] sr_rem_q;
	logic [RW-1:0] sr_root_q;
	logic [4:0]    sr_cnt_q;
	logic          sr_busy_q, sr_done_q;
	logic [RW+3:0] sr_shift, sr_trial;
	logic          sr_ge;

	logic          mul_done_q;

	// finishing results
	logic [31:0]          mse_q;
	logic [15:0]          rmse_q;
	logic [RW-1:0]        rna_q, rnb_q, sqd_q;
	logic [AW-1:0]        den_q;
	logic signed [15:0]   cos_q;
	logic [15:0]          rel_q;

	logic [AW-1:0] x_mag;
	assign x_mag = x_q[AW-1] ? AW'(-x_q) : x_q;

	logic [DW-1:0] dv_num_in;
	logic [AW-1:0] dv_den_in;
	logic [AW-1:0] sr_in;

	always_comb begin
		case (cmd.step)
			vem_pkg::STEP_DIV_COS: begin
				dv_num_in = {2'b00, x_mag, 14'd0};
				dv_den_in = den_q;
			end
			vem_pkg::STEP_DIV_REL: begin
				dv_num_in = {(DW-RW-12)'(0), sqd_q, 12'd0};
				dv_den_in = AW'(rna_q);
			end
			default: begin
				dv_num_in = DW'(sq_q);
				dv_den_in = AW'(cnt_q);
			end
		endcase
		case (cmd.step)
			vem_pkg::STEP_SQ_REF:  sr_in = rs_q;
			vem_pkg::STEP_SQ_TEST: sr_in = ts_q;
			vem_pkg::STEP_SQ_DIFF: sr_in = sq_q;
			default:               sr_in = AW'(mse_q);
		endcase
	end

	logic is_div, is_sqrt;
	assign is_div  = (cmd.step == vem_pkg::STEP_DIV_MSE) ||
	                 (cmd.step == vem_pkg::STEP_DIV_COS) ||
	                 (cmd.step == vem_pkg::STEP_DIV_REL);
	assign is_sqrt = (cmd.step == vem_pkg::STEP_SQ_MSE)  ||
	                 (cmd.step == vem_pkg::STEP_SQ_REF)  ||
	                 (cmd.step == vem_pkg::STEP_SQ_TEST) ||
	                 (cmd.step == vem_pkg::STEP_SQ_DIFF);

	assign dv_shift = {dv_rem_q, dv_num_q[DW-1]};
	assign dv_ge    = dv_shift >= {1'b0, dv_den_q};
	assign sr_shift = {sr_rem_q, sr_val_q[AW-1:AW-2]};
	assign sr_trial = {2'b00, sr_root_q, 2'b01};
	assign sr_ge    = sr_shift >= sr_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q  <= 1'b0;
			dv_done_q  <= 1'b0;
			dv_cnt_q   <= '0;
			sr_busy_q  <= 1'b0;
			sr_done_q  <= 1'b0;
			sr_cnt_q   <= '0;
			mul_done_q <= 1'b0;
		end else begin
			dv_done_q  <= 1'b0;
			sr_done_q  <= 1'b0;
			mul_done_q <= cmd.start && (cmd.step == vem_pkg::STEP_MUL_DEN);
			if (cmd.start && is_div) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q  <= 7'(DW);
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q - 7'd1;
				if (dv_cnt_q == 7'd1) begin
					dv_busy_q <= 1'b0;
					dv_done_q <= 1'b1;
				end
			end
			if (cmd.start && is_sqrt) begin
				sr_busy_q <= 1'b1;
				sr_cnt_q  <= 5'(RW);
			end else if (sr_busy_q) begin
				sr_cnt_q <= sr_cnt_q - 5'd1;
				if (sr_cnt_q == 5'd1) begin
					sr_busy_q <= 1'b0;
					sr_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && is_div) begin
			dv_num_q <= dv_num_in;
			dv_den_q <= dv_den_in;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_busy_q) begin
			dv_num_q <= {dv_num_q[DW-2:0], 1'b0};
			dv_rem_q <= dv_ge ? AW'(dv_shift - {1'b0, dv_den_q}) : dv_shift[AW-1:0];
			dv_quo_q <= {dv_quo_q[DW-2:0], dv_ge};
		end
		if (cmd.start && is_sqrt) begin
			sr_val_q  <= sr_in;
			sr_rem_q  <= '0;
			sr_root_q <= '0;
		end else if (sr_busy_q) begin
			sr_val_q  <= {sr_val_q[AW-3:0], 2'b00};
			sr_rem_q  <= sr_ge ? (RW+2)'(sr_shift - sr_trial) : sr_shift[RW+1:0];
			sr_root_q <= {sr_root_q[RW-2:0], sr_ge};
		end
	end

	// capture each step's result when its unit finishes
	always_ff @(posedge clk) begin
		if (mul_done_q) den_q <= rna_q * rnb_q;
		if (dv_done_q) begin
			case (cmd.step)
				vem_pkg::STEP_DIV_MSE: begin
					if (cnt_q == '0)                mse_q <= '0;
					else if (dv_quo_q[DW-1:32] != '0) mse_q <= '1;
					else                            mse_q <= dv_quo_q[31:0];
				end
				vem_pkg::STEP_DIV_COS: begin
					if (den_q == '0)
						cos_q <= '0;
					else if (dv_quo_q > DW'(16384))
						cos_q <= x_q[AW-1] ? -16'sd16384 : 16'sd16384;
					else
						cos_q <= x_q[AW-1] ? -$signed(dv_quo_q[15:0])
						                   : $signed(dv_quo_q[15:0]);
				end
				vem_pkg::STEP_DIV_REL: begin
					if (rna_q == '0)                 rel_q <= '0;
					else if (dv_quo_q[DW-1:16] != '0) rel_q <= '1;
					else                             rel_q <= dv_quo_q[15:0];
				end
				default: rel_q <= rel_q;
			endcase
		end
		if (sr_done_q) begin
			case (cmd.step)
				vem_pkg::STEP_SQ_MSE:  rmse_q <= sr_root_q[15:0];
				vem_pkg::STEP_SQ_REF:  rna_q  <= sr_root_q;
				vem_pkg::STEP_SQ_TEST: rnb_q  <= sr_root_q;
				vem_pkg::STEP_SQ_DIFF: sqd_q  <= sr_root_q;
				default:               sqd_q  <= sqd_q;
			endcase
		end
	end

	// ---------------- result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			mean_sq_err      <= mse_q;
			root_mean_sq_err <= rmse_q;
			peak_abs_err     <= peak_q[16] ? 16'hFFFF : peak_q[15:0];
			cosine_sim       <= cos_q;
			relative_l2      <= rel_q;
			length_overflow  <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.unit_done = dv_done_q | sr_done_q | mul_done_q;
	assign status.out_busy  = out_valid_q && !out_ready;

endmodule

// File: sv/vector_error_metrics.sv
// ----------------------------------------------------------------------------
// vector_error_metrics: MSE, RMSE, peak error, cosine and relative L2
// One pair accepted per cycle while a vector streams in; after the last
// pair the metrics are finished by a shared divider and square root.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle within a vector.
// Finishing: after the last pair, three 64-step divides and four 24-step
//   roots run on the shared units; publishing is held while the previous
//   result still waits to be taken.
// No pairs are taken during that finishing sequence.
// Reset: arst_n clears all accumulators, counters and valid flags.
module vector_error_metrics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample_ref[15:0], sample_test[31:16]
	input  logic        s_axis_tlast,  // last_pair
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // mean_sq_err[31:0], root_mean_sq_err[47:32],
	                                   // peak_abs_err[63:48], cosine_sim[79:64],
	                                   // relative_l2[95:80]
	output logic        m_axis_tuser   // length_overflow
);

	vem_pkg::vem_cmd_t    cmd;
	vem_pkg::vem_status_t status;

	logic               in_accept;
	logic [31:0]        mse;
	logic [15:0]        rmse, peak, rel;
	logic signed [15:0] cosv;

	assign s_axis_tready = cmd.in_en;
	assign in_accept     = s_axis_tvalid && cmd.in_en;

	vem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_accept),
		.in_last  (s_axis_tlast),
		.status   (status),
		.cmd      (cmd)
	);

	vem_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_accept        (in_accept),
		.sample_ref       (s_axis_tdata[15:0]),
		.sample_test      (s_axis_tdata[31:16]),
		.out_ready        (m_axis_tready),
		.out_valid        (m_axis_tvalid),
		.mean_sq_err      (mse),
		.root_mean_sq_err (rmse),
		.peak_abs_err     (peak),
		.cosine_sim       (cosv),
		.relative_l2      (rel),
		.length_overflow  (m_axis_tuser)
	);

	assign m_axis_tdata = {rel, cosv, peak, rmse, mse};

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(cosv) <= 16'sd16384 && $signed(cosv) >= -16'sd16384))
		else $error("cosine out of range");

	a_rmse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mse == 32'd0 |-> rmse == 16'd0)
		else $error("rmse nonzero for zero mse");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken during finishing");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for vector_error_metrics
// Streams sample pairs with random bursts and gaps and a stalling result
// side, predicts each vector's metrics and compares every result field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIN_LAT   = 400;
	localparam int WD_LIMIT  = 20000;
	localparam longint U48M  = 48'hFFFF_FFFF_FFFF;
	localparam longint S48MX = 64'sh7FFF_FFFF_FFFF;
	localparam longint S48MN = -64'sh8000_0000_0000;

	typedef struct packed {
		logic [15:0] sref;
		logic [15:0] stest;
		logic        last;
	} pair_t;

	typedef struct packed {
		logic [31:0] mse;
		logic [15:0] rmse;
		logic [15:0] peak;
		logic [15:0] cosv;
		logic [15:0] rel;
		logic        ovf;
	} metrics_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	vector_error_metrics DUT (.*);

	always #6 clk = ~clk;

	pair_t    pending[$];
	metrics_t expected_metrics[$];
	int       errors = 0;
	bit       hold_off = 0;

	// running sums of the predictor
	longint unsigned n_pairs, sq_sum, pk, rsq, tsq;
	longint          xsum;
	bit              ovf_seen;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned sat_add48(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > U48M) ? U48M : s;
	endfunction

	task automatic clear_sums();
		n_pairs = 0; sq_sum = 0; pk = 0; rsq = 0; tsq = 0; xsum = 0; ovf_seen = 0;
	endtask

	task automatic accumulate_pair(pair_t p);
		longint r, t, d, s;
		longint unsigned ad, mse, rmse, rna, rnb, rel;
		longint cosv;
		metrics_t m;
		r = longint'(signed'(p.sref));
		t = longint'(signed'(p.stest));
		if (n_pairs >= vem_pkg::MAX_LEN)
			ovf_seen = 1;
		else begin
			d = r - t;
			ad = (d < 0) ? -d : d;
			sq_sum = sat_add48(sq_sum, ad * ad);
			if (ad > pk) pk = ad;
			s = xsum + r * t;
			if (s > S48MX) s = S48MX;
			if (s < S48MN) s = S48MN;
			xsum = s;
			rsq = sat_add48(rsq, r * r);
			tsq = sat_add48(tsq, t * t);
			n_pairs++;
		end
		if (!p.last) return;
		rna = int_sqrt(rsq);
		rnb = int_sqrt(tsq);
		mse = (n_pairs != 0) ? sq_sum / n_pairs : 0;
		if (mse > 64'hFFFF_FFFF) mse = 64'hFFFF_FFFF;
		rmse = int_sqrt(mse);
		if (rmse > 16'hFFFF) rmse = 16'hFFFF;
		cosv = 0;
		if (rna != 0 && rnb != 0) begin
			cosv = (xsum * 16384) / longint'(rna * rnb);
			if (cosv > 16384) cosv = 16384;
			if (cosv < -16384) cosv = -16384;
		end
		rel = 0;
		if (rna != 0) begin
			rel = (int_sqrt(sq_sum) * 4096) / rna;
			if (rel > 16'hFFFF) rel = 16'hFFFF;
		end
		m.mse = mse[31:0];
		m.rmse = rmse[15:0];
		m.peak = (pk > 16'hFFFF) ? 16'hFFFF : pk[15:0];
		m.cosv = cosv[15:0];
		m.rel = rel[15:0];
		m.ovf = ovf_seen;
		expected_metrics.push_back(m);
		clear_sums();
	endtask

	// driver: bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				accumulate_pair(pair_t'({s_axis_tdata[15:0], s_axis_tdata[31:16],
				                         s_axis_tlast}));
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 0;
				end else if (pending.size() == 0) begin
					s_axis_tvalid <= 0;
				end else begin
					pair_t p;
					p = pending.pop_front();
					s_axis_tdata <= {p.stest, p.sref};
					s_axis_tlast <= p.last;
					s_axis_tvalid <= 1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end
				end
			end
		end
	end

	// receiver stall pattern plus one long hold-off
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase = (stall_phase + 1) % 37;
			if (hold_off)
				m_axis_tready <= 0;
			else if (stall_phase < 12)
				m_axis_tready <= 1;
			else
				m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			metrics_t got, exp_m;
			got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
			       m_axis_tdata[79:64], m_axis_tdata[95:80], m_axis_tuser};
			if (expected_metrics.size() == 0) begin
				$error("result with no expectation pending");
				errors++;
			end else begin
				exp_m = expected_metrics.pop_front();
				if (got.mse !== exp_m.mse) begin
					$error("mean_sq_err exp %0d got %0d", exp_m.mse, got.mse); errors++;
				end
				if (got.rmse !== exp_m.rmse) begin
					$error("root_mean_sq_err exp %0d got %0d", exp_m.rmse, got.rmse); errors++;
				end
				if (got.peak !== exp_m.peak) begin
					$error("peak_abs_err exp %0d got %0d", exp_m.peak, got.peak); errors++;
				end
				if (got.cosv !== exp_m.cosv) begin
					$error("cosine_sim exp %0d got %0d", $signed(exp_m.cosv),
					       $signed(got.cosv));
					errors++;
				end
				if (got.rel !== exp_m.rel) begin
					$error("relative_l2 exp %0d got %0d", exp_m.rel, got.rel); errors++;
				end
				if (got.ovf !== exp_m.ovf) begin
					$error("length_overflow exp %0d got %0d", exp_m.ovf, got.ovf); errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else if (!hold_off)
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_vec(int len, int kind);
		pair_t p;
		for (int i = 0; i < len; i++) begin
			p.sref = rand_sample();
			case (kind)
				0: p.stest = rand_sample();
				1: p.stest = p.sref;
				2: p.stest = p.sref + 16'($signed($urandom_range(0, 16)) - 8);
				default: p.stest = -p.sref;
			endcase
			p.last = (i == len - 1);
			pending.push_back(p);
		end
	endtask

	int total;
	initial begin
		clear_sums();
		// directed: extremes, equal, opposite, zero norms, single pair
		pending.push_back('{16'h7FFF, 16'h8000, 1});
		pending.push_back('{16'h8000, 16'h7FFF, 1});
		pending.push_back('{16'h8000, 16'h8000, 1});
		pending.push_back('{16'h0000, 16'h0000, 1});
		pending.push_back('{16'h0000, 16'h1000, 0});
		pending.push_back('{16'h0000, 16'h8000, 1});
		pending.push_back('{16'h1000, 16'h0000, 0});
		pending.push_back('{16'h7FFF, 16'h0000, 1});
		pending.push_back('{16'h1234, 16'h1234, 0});
		pending.push_back('{16'hEDCC, 16'hEDCC, 1});
		pending.push_back('{16'h4000, 16'hC000, 0});
		pending.push_back('{16'h7FFF, 16'h8001, 1});
		pending.push_back('{16'h0001, 16'hFFFF, 1});
		pending.push_back('{16'hFFFF, 16'hFFFF, 1});
		push_vec(5, 0);
		repeat (8) @(posedge clk);
		arst_n <= 1;
		// random vectors, mostly short
		total = 0;
		while (total < 600) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			push_vec(len, $urandom_range(0, 3));
			total += len;
		end
		// long hold-off on the result side while pairs keep coming
		while (expected_metrics.size() == 0) @(posedge clk);
		hold_off = 1;
		repeat (3000) @(posedge clk);
		hold_off = 0;
		while (pending.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_metrics.size() != 0) @(posedge clk);
		repeat (FIN_LAT) @(posedge clk);
		if (errors == 0 && expected_metrics.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
